/* hdl/smd_pkg.sv */
// Package for the signed multiset difference block: widths, codes, entry and port types.
`default_nettype none

package smd_pkg;

    // Store geometry
    localparam int MAX_VARIABLES = 256;
    localparam int COUNT_W       = 16;
    localparam int IDX_W         = 9;
    localparam int ADDR_W        = $clog2(MAX_VARIABLES);
    localparam int TOTAL_W       = $clog2(MAX_VARIABLES + 1);

    // Stream and register port widths
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Register map
    localparam logic [APB_ADDR_W-1:0] REG_VARIABLES_IN_USE = 2'd0;
    localparam logic [IDX_W-1:0]      VARIABLES_RESET      = 9'd256;

    // Operation codes
    localparam logic [1:0] OP_INC    = 2'd0;
    localparam logic [1:0] OP_DEC    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Relation codes
    localparam logic [1:0] REL_EQUAL        = 2'd0;
    localparam logic [1:0] REL_GREATER      = 2'd1;
    localparam logic [1:0] REL_LESS         = 2'd2;
    localparam logic [1:0] REL_INCOMPARABLE = 2'd3;

    // Counter limits
    localparam logic [COUNT_W-1:0] CNT_MAX   = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic [COUNT_W-1:0] CNT_MIN   = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] CNT_ONE   = {{(COUNT_W-1){1'b0}}, 1'b1};
    localparam logic [COUNT_W-1:0] CNT_M_ONE = {COUNT_W{1'b1}};

    // One store entry: link of the touched list and the occurrence counter
    typedef struct packed {
        logic [IDX_W-1:0]   link;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // Store access request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              inv_en;
        logic [ADDR_W-1:0] inv_addr;
    } mem_req_t;

    // Relation from the two totals
    function automatic logic [1:0] relation_of(input logic pos_nz, input logic neg_nz);
        logic [1:0] rel;
        if (pos_nz && neg_nz)
        begin
            rel = REL_INCOMPARABLE;
        end
        else if (pos_nz)
        begin
            rel = REL_GREATER;
        end
        else if (neg_nz)
        begin
            rel = REL_LESS;
        end
        else
        begin
            rel = REL_EQUAL;
        end
        return rel;
    endfunction

endpackage

`default_nettype wire

/* hdl/smd_entry_mem.sv */
// Counter and link store with per-entry valid bits; an invalid entry reads as zero.
`default_nettype none

module smd_entry_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smd_pkg::mem_req_t req,
    output smd_pkg::entry_t        rd_data
);

    smd_pkg::entry_t mem [smd_pkg::MAX_VARIABLES];
    logic [smd_pkg::MAX_VARIABLES-1:0] valid_reg;
    smd_pkg::entry_t rd_data_reg;
    logic            rd_valid_reg;

    // Write port and registered read port of the array
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Track which entries hold live data; drop an entry when the list walk clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.inv_en)
            begin
                valid_reg[req.inv_addr] <= 1'b0;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* hdl/signed_multiset_difference.sv */
// Top level of the signed multiset difference block: sequencer, totals and ports.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------
//  s_*       | in        | s_tvalid / s_tready     | s_tdata var_index, s_tuser operation
//  m_*       | out       | m_tvalid / m_tready     | m_tdata relation and flags
//  APB       | in        | psel, penable, pready=1 | variables_in_use at address 0
//
//  Increment and decrement read the store entry when accepted; the update state then
//  steps it through the shared add unit, writes it back unless the index is bad or it
//  saturates, and loads the result. The unused code goes straight to the finish state.
//  Clear reads each touched entry's link, then invalidates it, and then finishes.
//  s_tready is high only while the sequencer is idle; a result held in the output
//  register stalls the final cycle of the next transaction until it is taken.
//  Reset empties the store at once through per-entry valid bits: no clearing pass.
`default_nettype none

module signed_multiset_difference (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [smd_pkg::IN_DATA_W-1:0]     s_tdata,  // [8:0] var_index
    input  wire logic [smd_pkg::IN_USER_W-1:0]     s_tuser,  // [1:0] operation
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [smd_pkg::OUT_DATA_W-1:0]         m_tdata,  // [1:0] relation,
                                                             // [2] no_positive,
                                                             // [3] no_negative,
                                                             // [4] index_error,
                                                             // [5] saturated
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [smd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [smd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [smd_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK_RD,
        ST_WALK_STEP,
        ST_FINISH
    } state_t;

    localparam logic [smd_pkg::IDX_W-1:0]   IDX_MAX   = smd_pkg::IDX_W'(smd_pkg::MAX_VARIABLES);
    localparam logic [smd_pkg::TOTAL_W-1:0] STEPS_MAX =
        smd_pkg::TOTAL_W'(smd_pkg::MAX_VARIABLES);

    state_t                        state_reg;
    logic [smd_pkg::IDX_W-1:0]     variables_reg;
    logic [1:0]                    op_reg;
    logic [smd_pkg::IDX_W-1:0]     idx_reg;
    logic                          err_reg;
    logic [smd_pkg::IDX_W-1:0]     head_reg;
    logic [smd_pkg::TOTAL_W-1:0]   pos_total_reg;
    logic [smd_pkg::TOTAL_W-1:0]   neg_total_reg;
    logic [smd_pkg::IDX_W-1:0]     cur_reg;
    logic [smd_pkg::TOTAL_W-1:0]   steps_reg;
    logic                          m_tvalid_reg;
    logic [smd_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    smd_pkg::mem_req_t             mem_req;
    smd_pkg::entry_t               rd_entry;

    logic                          cfg_write;
    logic                          in_accept;
    logic                          out_free;
    logic                          out_load;
    logic [smd_pkg::IDX_W-1:0]     limit;
    logic [smd_pkg::IDX_W-1:0]     in_idx;
    logic                          in_err;
    logic                          is_inc;
    logic                          sat;
    logic                          do_wr;
    logic                          push;
    logic [smd_pkg::COUNT_W-1:0]   unit_a;
    logic                          unit_dec;
    logic [smd_pkg::COUNT_W-1:0]   unit_sum;
    logic [smd_pkg::TOTAL_W-1:0]   pos_next;
    logic [smd_pkg::TOTAL_W-1:0]   neg_next;
    logic [smd_pkg::IDX_W-1:0]     link_next;
    logic                          walk_stop;
    logic [smd_pkg::OUT_DATA_W-1:0] exec_result;
    logic [smd_pkg::OUT_DATA_W-1:0] finish_result;

    smd_entry_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_entry)
    );

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == smd_pkg::REG_VARIABLES_IN_USE);
    assign prdata    = (paddr == smd_pkg::REG_VARIABLES_IN_USE)
                       ? smd_pkg::APB_DATA_W'(variables_reg) : '0;

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = ((state_reg == ST_EXEC) || (state_reg == ST_FINISH)) && out_free;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Index check against the clamped register
    assign limit  = (variables_reg > IDX_MAX) ? IDX_MAX : variables_reg;
    assign in_idx = s_tdata[smd_pkg::IDX_W-1:0];
    assign in_err = ((s_tuser == smd_pkg::OP_INC) || (s_tuser == smd_pkg::OP_DEC))
                    && ((in_idx == '0) || (in_idx > limit));

    // Shared add unit: counter step in the update cycle, walk step count otherwise
    always_comb
    begin
        if (state_reg == ST_EXEC)
        begin
            unit_a   = rd_entry.count;
            unit_dec = !is_inc;
        end
        else
        begin
            unit_a   = smd_pkg::COUNT_W'(steps_reg);
            unit_dec = 1'b0;
        end
        unit_sum = unit_dec ? (unit_a - smd_pkg::CNT_ONE) : (unit_a + smd_pkg::CNT_ONE);
    end

    // Update of one counter, its list link and the totals
    always_comb
    begin
        is_inc   = (op_reg == smd_pkg::OP_INC);
        sat      = is_inc ? (rd_entry.count == smd_pkg::CNT_MAX)
                          : (rd_entry.count == smd_pkg::CNT_MIN);
        do_wr    = !err_reg && !sat;
        pos_next = pos_total_reg;
        neg_next = neg_total_reg;
        push     = 1'b0;
        if (do_wr)
        begin
            if (unit_sum == '0)
            begin
                if (is_inc)
                begin
                    neg_next = neg_total_reg - 1'b1;
                end
                else
                begin
                    pos_next = pos_total_reg - 1'b1;
                end
            end
            else if (is_inc && (unit_sum == smd_pkg::CNT_ONE))
            begin
                pos_next = pos_total_reg + 1'b1;
                push     = (rd_entry.link == '0);
            end
            else if (!is_inc && (unit_sum == smd_pkg::CNT_M_ONE))
            begin
                neg_next = neg_total_reg + 1'b1;
                push     = (rd_entry.link == '0);
            end
        end
        link_next = push ? ((head_reg == '0) ? idx_reg : head_reg) : rd_entry.link;
        exec_result = {2'b00, !err_reg && sat, err_reg, neg_next == '0, pos_next == '0,
                       smd_pkg::relation_of(pos_next != '0, neg_next != '0)};
        if (op_reg == smd_pkg::OP_CLEAR)
        begin
            finish_result = {2'b00, 1'b0, 1'b0, 1'b1, 1'b1, smd_pkg::REL_EQUAL};
        end
        else
        begin
            finish_result = {2'b00, 1'b0, 1'b0, neg_total_reg == '0, pos_total_reg == '0,
                             smd_pkg::relation_of(pos_total_reg != '0,
                                                  neg_total_reg != '0)};
        end
    end

    // Stop the walk at an empty or out-of-range link, or after the step bound
    assign walk_stop = (cur_reg == '0) || (cur_reg > IDX_MAX) || (steps_reg == STEPS_MAX);

    // Store requests
    always_comb
    begin
        mem_req          = '0;
        mem_req.wr_addr  = smd_pkg::ADDR_W'(idx_reg - 1'b1);
        mem_req.wr_data  = '{link: link_next, count: unit_sum};
        mem_req.inv_addr = smd_pkg::ADDR_W'(cur_reg - 1'b1);
        mem_req.rd_addr  = in_accept ? smd_pkg::ADDR_W'(in_idx - 1'b1)
                                     : smd_pkg::ADDR_W'(cur_reg - 1'b1);
        mem_req.rd_en    = in_accept || ((state_reg == ST_WALK_RD) && !walk_stop);
        mem_req.wr_en    = (state_reg == ST_EXEC) && out_free && do_wr;
        mem_req.inv_en   = (state_reg == ST_WALK_STEP);
    end

    // Sequencer, totals and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            variables_reg <= smd_pkg::VARIABLES_RESET;
            op_reg        <= smd_pkg::OP_UNUSED;
            idx_reg       <= '0;
            err_reg       <= 1'b0;
            head_reg      <= '0;
            pos_total_reg <= '0;
            neg_total_reg <= '0;
            cur_reg       <= '0;
            steps_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                variables_reg <= pwdata[smd_pkg::IDX_W-1:0];
            end
            // load a new result, or drop one once it has been taken
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg    <= s_tuser;
                        idx_reg   <= in_idx;
                        err_reg   <= in_err;
                        cur_reg   <= head_reg;
                        steps_reg <= '0;
                        if ((s_tuser == smd_pkg::OP_INC) || (s_tuser == smd_pkg::OP_DEC))
                        begin
                            state_reg <= ST_EXEC;
                        end
                        else if (s_tuser == smd_pkg::OP_CLEAR)
                        begin
                            state_reg <= ST_WALK_RD;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_EXEC:
                begin
                    if (out_free)
                    begin
                        pos_total_reg <= pos_next;
                        neg_total_reg <= neg_next;
                        if (push)
                        begin
                            head_reg <= idx_reg;
                        end
                        m_tdata_reg  <= exec_result;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_WALK_RD:
                begin
                    state_reg <= walk_stop ? ST_FINISH : ST_WALK_STEP;
                end
                ST_WALK_STEP:
                begin
                    steps_reg <= unit_sum[smd_pkg::TOTAL_W-1:0];
                    cur_reg   <= rd_entry.link;
                    state_reg <= (rd_entry.link == cur_reg) ? ST_FINISH : ST_WALK_RD;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        if (op_reg == smd_pkg::OP_CLEAR)
                        begin
                            head_reg      <= '0;
                            pos_total_reg <= '0;
                            neg_total_reg <= '0;
                        end
                        m_tdata_reg  <= finish_result;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // An empty list means every counter is zero
    a_empty_list_no_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == '0) |-> ((pos_total_reg == '0) && (neg_total_reg == '0)))
        else $error("totals nonzero with empty touched list");

    // Totals never exceed the number of variables
    a_totals_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ((smd_pkg::TOTAL_W + 1)'(pos_total_reg) + (smd_pkg::TOTAL_W + 1)'(neg_total_reg))
        <= (smd_pkg::TOTAL_W + 1)'(smd_pkg::MAX_VARIABLES))
        else $error("counter totals exceed store depth");

    // A bad index never writes the store, and no write coincides with an invalidate
    a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (!err_reg && !mem_req.inv_en))
        else $error("store write on bad index or during walk");

    // A valid result never flags both a bad index and saturation
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[4] && m_tdata_reg[5]))
        else $error("index error and saturation reported together");

    // After a clear completes the relation is equal
    a_clear_equal: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free && (op_reg == smd_pkg::OP_CLEAR))
        |=> ((head_reg == '0) && (m_tdata_reg[1:0] == smd_pkg::REL_EQUAL)))
        else $error("clear left a nonempty relation");

endmodule

`default_nettype wire

/* verif/smd_checker.sv */
// Checker for the signed multiset difference block: watches the streams and the register port.
`default_nettype none

module smd_checker
    import smd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // [8:0] var_index
    input  wire logic [IN_USER_W-1:0]   s_tuser,   // [1:0] operation
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_DATA_W-1:0]  m_tdata,   // [1:0] relation, [2] no_positive,
                                                   // [3] no_negative, [4] index_error,
                                                   // [5] saturated
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    input  wire logic                   pready,
    output int                          results_seen,
    output int                          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_TOP    = (1 << (COUNT_W - 1)) - 1;
    localparam int COUNT_BOTTOM = -COUNT_TOP - 1;
    localparam int REPORT_MAX   = 10;

    // Status word, lowest field last so that it lands in the lowest bits
    typedef struct packed {
        logic       saturated;
        logic       index_error;
        logic       no_negative;
        logic       no_positive;
        logic [1:0] relation;
    } status_t;

    // Own copy of the block's state
    logic signed [COUNT_W-1:0] occ_count  [1:MAX_VARIABLES];
    logic [IDX_W-1:0]          touch_link [1:MAX_VARIABLES];
    logic [IDX_W-1:0]          touch_head;
    logic [TOTAL_W-1:0]        pos_total;
    logic [TOTAL_W-1:0]        neg_total;
    logic [IDX_W-1:0]          var_limit;

    status_t status_due [$];
    int      seen_n;
    int      fails_n;

    // Put an index at the head of the touched list the first time it goes nonzero
    function automatic void push_touched(input logic [IDX_W-1:0] idx);
        if (touch_link[idx] == '0)
        begin
            touch_link[idx] = (touch_head == '0) ? idx : touch_head;
            touch_head      = idx;
        end
    endfunction

    // Walk the touched list, zeroing counters and links; stop on a bad link
    function automatic void clear_touched();
        int cur;
        int nxt;
        int steps;
        cur   = touch_head;
        steps = 0;
        while (cur != 0 && cur <= MAX_VARIABLES && steps < MAX_VARIABLES)
        begin
            nxt             = touch_link[cur];
            occ_count[cur]  = '0;
            touch_link[cur] = '0;
            steps++;
            if (nxt == cur)
            begin
                break;
            end
            cur = nxt;
        end
        touch_head = '0;
    endfunction

    // Apply one input transaction and return the status it should produce
    function automatic status_t advance_multiset(input logic [1:0] op,
                                                 input logic [IDX_W-1:0] idx);
        status_t     st;
        int unsigned lim;
        int          c;
        st  = '0;
        lim = (var_limit > MAX_VARIABLES) ? MAX_VARIABLES : var_limit;
        if (op == OP_INC || op == OP_DEC)
        begin
            if (idx < 1 || idx > lim)
            begin
                st.index_error = 1'b1;
            end
            else
            begin
                c = occ_count[idx];
                if (op == OP_INC)
                begin
                    if (c >= COUNT_TOP)
                    begin
                        st.saturated = 1'b1;
                    end
                    else
                    begin
                        c++;
                        occ_count[idx] = c[COUNT_W-1:0];
                        if (c == 0)
                        begin
                            neg_total--;
                        end
                        else if (c == 1)
                        begin
                            pos_total++;
                            push_touched(idx);
                        end
                    end
                end
                else
                begin
                    if (c <= COUNT_BOTTOM)
                    begin
                        st.saturated = 1'b1;
                    end
                    else
                    begin
                        c--;
                        occ_count[idx] = c[COUNT_W-1:0];
                        if (c == 0)
                        begin
                            pos_total--;
                        end
                        else if (c == -1)
                        begin
                            neg_total++;
                            push_touched(idx);
                        end
                    end
                end
            end
        end
        else if (op == OP_CLEAR)
        begin
            clear_touched();
            pos_total = '0;
            neg_total = '0;
        end

        // Relation between the two multisets after the item
        if (pos_total != 0 && neg_total != 0)
        begin
            st.relation = REL_INCOMPARABLE;
        end
        else if (pos_total != 0)
        begin
            st.relation = REL_GREATER;
        end
        else if (neg_total != 0)
        begin
            st.relation = REL_LESS;
        end
        else
        begin
            st.relation = REL_EQUAL;
        end
        st.no_positive = (pos_total == 0);
        st.no_negative = (neg_total == 0);
        return st;
    endfunction

    // Count a wrong field and report the first few
    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            fails_n++;
            if (fails_n <= REPORT_MAX)
            begin
                $display("%0t: result %0d field %s: expected %0d, got %0d",
                         $realtime, seen_n, name, want, got);
            end
        end
    endfunction

    // Compare one result transaction with the oldest expectation
    function automatic void check_status(input logic [OUT_DATA_W-1:0] word);
        status_t want;
        status_t got;
        got = word[5:0];
        seen_n++;
        if (status_due.size() == 0)
        begin
            fails_n++;
            if (fails_n <= REPORT_MAX)
            begin
                $display("%0t: result %0d arrived with nothing expected (tdata 0x%02h)",
                         $realtime, seen_n, word);
            end
        end
        else
        begin
            want = status_due.pop_front();
            compare_field("relation", want.relation, got.relation);
            compare_field("no_positive", want.no_positive, got.no_positive);
            compare_field("no_negative", want.no_negative, got.no_negative);
            compare_field("index_error", want.index_error, got.index_error);
            compare_field("saturated", want.saturated, got.saturated);
        end
    endfunction

    // Monitor: results first, then register writes, then new input transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= MAX_VARIABLES; i++)
            begin
                occ_count[i]  = '0;
                touch_link[i] = '0;
            end
            touch_head = '0;
            pos_total  = '0;
            neg_total  = '0;
            var_limit  = VARIABLES_RESET;
            status_due.delete();
            seen_n       = 0;
            fails_n      = 0;
            results_seen <= 0;
            fail_count   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_status(m_tdata);
            end
            if (psel && penable && pwrite && pready && paddr == REG_VARIABLES_IN_USE)
            begin
                var_limit = pwdata[IDX_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                status_due.push_back(advance_multiset(s_tuser, s_tdata[IDX_W-1:0]));
            end
            results_seen <= seen_n;
            fail_count   <= fails_n;
        end
    end

endmodule

`default_nettype wire

/* verif/signed_multiset_difference_tb.sv */
// Testbench top for the signed multiset difference block: clock, reset, stimulus and verdict.
`default_nettype none

module signed_multiset_difference_tb;
    import smd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 345;
    localparam int IDLE_PERCENT = 12;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [8:0] var_index
    logic [IN_USER_W-1:0]  s_tuser;   // [1:0] operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [1:0] relation, [2] no_positive, [3] no_negative,
                                      // [4] index_error, [5] saturated
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          results_seen;
    int          fail_count;
    int          items_sent;
    int          stall_cycles;
    bit          calm;
    int unsigned limit_now;

    signed_multiset_difference DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    smd_checker CHECK (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .results_seen (results_seen),
        .fail_count   (fail_count)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random idle decision, suppressed during calm stretches
    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // Result side: hold ready low in reset, then stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !idle_roll();
        end
    end

    // Watchdog: fail when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one input transaction, with a random gap ahead of it
    task automatic push_item(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        while (idle_roll())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_DATA_W-IDX_W){1'b0}}, idx};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
    endtask

    // Drop valid and hold until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_seen < items_sent)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic write_limit(input logic [IDX_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_VARIABLES_IN_USE;
        pwdata  <= {{(APB_DATA_W-IDX_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_now = value;
    endtask

    // Mostly well-formed updates on a few indices, plus clears, bad indices and noise
    task automatic random_item();
        int unsigned eff;
        int unsigned hi;
        int unsigned roll;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        eff  = (limit_now > MAX_VARIABLES) ? MAX_VARIABLES : limit_now;
        hi   = (eff > 12) ? 12 : eff;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            op = $urandom_range(0, 1) ? OP_DEC : OP_INC;
            if ($urandom_range(0, 3) == 0)
            begin
                idx = IDX_W'($urandom_range(1, eff));
            end
            else
            begin
                idx = IDX_W'($urandom_range(1, hi));
            end
        end
        else if (roll < 75)
        begin
            op  = OP_CLEAR;
            idx = IDX_W'($urandom);
        end
        else if (roll < 80)
        begin
            op  = OP_UNUSED;
            idx = IDX_W'($urandom);
        end
        else if (roll < 90)
        begin
            op  = $urandom_range(0, 1) ? OP_DEC : OP_INC;
            idx = ($urandom_range(0, 3) == 0) ? '0 : IDX_W'($urandom_range(eff + 1, 511));
        end
        else
        begin
            op  = 2'($urandom);
            idx = IDX_W'($urandom);
        end
        push_item(op, idx);
    endtask

    initial
    begin
        int unsigned phase_limit [5];
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_INC;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = REG_VARIABLES_IN_USE;
        pwdata       = '0;
        items_sent   = 0;
        calm         = 1'b0;
        limit_now    = VARIABLES_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: relations, bad indices, unused code and clears at the reset limit
        push_item(OP_INC, 9'd1);
        push_item(OP_INC, 9'd1);
        push_item(OP_DEC, 9'd1);
        push_item(OP_DEC, 9'd1);
        push_item(OP_DEC, 9'd2);
        push_item(OP_INC, 9'd3);
        push_item(OP_UNUSED, 9'd511);
        push_item(OP_INC, 9'd0);
        push_item(OP_INC, 9'd256);
        push_item(OP_DEC, 9'd257);
        push_item(OP_INC, 9'd511);
        push_item(OP_CLEAR, 9'h155);
        push_item(OP_CLEAR, 9'd0);
        push_item(OP_DEC, 9'd256);
        push_item(OP_UNUSED, 9'd0);
        push_item(OP_INC, 9'd256);
        drain();

        // Limit of one, zero limit, and a limit beyond the store
        write_limit(9'd1);
        push_item(OP_INC, 9'd1);
        push_item(OP_INC, 9'd2);
        push_item(OP_CLEAR, 9'd0);
        drain();
        write_limit(9'd0);
        push_item(OP_INC, 9'd1);
        push_item(OP_DEC, 9'd0);
        push_item(OP_UNUSED, 9'd1);
        drain();
        write_limit(9'd511);
        push_item(OP_INC, 9'd256);
        push_item(OP_DEC, 9'd257);
        push_item(OP_CLEAR, 9'd0);
        drain();

        // Touch every index, then clear the full list
        write_limit(9'd256);
        for (int i = 1; i <= MAX_VARIABLES; i++)
        begin
            push_item((i % 2) ? OP_INC : OP_DEC, IDX_W'(i));
        end
        push_item(OP_CLEAR, 9'd0);
        drain();

        // Random phases over several limits
        phase_limit[0] = 256;
        phase_limit[1] = 16;
        phase_limit[2] = $urandom_range(2, 255);
        phase_limit[3] = 511;
        phase_limit[4] = 1;
        for (int p = 0; p < 5; p++)
        begin
            write_limit(IDX_W'(phase_limit[p]));
            calm = (p == 1);
            repeat (PHASE_ITEMS) random_item();
            drain();
        end
        calm = 1'b0;

        repeat (16) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
